### design/bounded_id_set_table_unit_assert.svh
// Assertion helpers for the ID set table.
`ifndef BOUNDED_ID_SET_TABLE_UNIT_ASSERT_SVH
`define BOUNDED_ID_SET_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BIST_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bist check failed");

// Next-cycle implication.
`define BIST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bist check failed");

`endif

### design/bist_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bist_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int CNT_W           = 5;
  localparam int ID_W            = 32;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_PRESENT   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    op_t                    opcode;
    logic signed [ID_W-1:0] item_id;
  } in_t;

  typedef struct packed {
    logic             success;
    status_t          status;
    logic [CNT_W-1:0] entry_count;
  } out_t;

endpackage

`default_nettype wire

### design/bist_store.sv
`timescale 1ns / 1ps
`default_nettype none

module bist_store
  import bist_pkg::*;
#(
  parameter int DEPTH = MAX_ENTRIES_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic            clk,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output logic      [ID_W-1:0] rd_data,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire logic [ID_W-1:0] wr_data
);

  logic [ID_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### design/bounded_id_set_table_unit.sv
// Ordered ID set with a shared scan over the table. start is taken
// while busy is low; each item gives one result on result, flagged by done for
// one cycle, and the receiver cannot stall it. Clear gives its result in the
// cycle after start. Add and query scan the table, which is read one entry per
// cycle through a registered read port and compared by one comparator. Remove
// scans up to the match and then moves each later entry down one place, one
// read and one write per cycle. A new start is taken in the cycle done is high.
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_id_set_table_unit_assert.svh"

module bounded_id_set_table_unit
  import bist_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire in_t              cmd,
  output logic                  done,
  output out_t                  result,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata
);

  localparam int IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int PtrW = (IdxW + 1 > CNT_W) ? IdxW + 1 : CNT_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

  state_t            state, state_next;
  op_t               op_r, op_next;
  logic [ID_W-1:0]   id_r, id_next;
  logic [PtrW-1:0]   count_r, count_next;
  logic [CNT_W-1:0]  max_r;
  logic [PtrW-1:0]   idx, idx_next;
  logic              cmp_vld, cmp_vld_next;
  logic [PtrW-1:0]   cmp_idx, cmp_idx_next;
  logic              done_next;
  out_t              result_next;

  logic              rd_en, wr_en;
  logic [IdxW-1:0]   rd_addr, wr_addr;
  logic [ID_W-1:0]   rd_data, wr_data;

  logic              hit, full, scan_end;
  logic [PtrW-1:0]   count_inc, count_dec, shift_dst;

  bist_store #(
    .DEPTH (MAX_ENTRIES),
    .AW    (IdxW)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign busy      = (state != S_IDLE);
  assign hit       = cmp_vld && (rd_data == id_r);
  assign full      = (count_r >= PtrW'(max_r)) || (count_r >= PtrW'(MAX_ENTRIES));
  assign scan_end  = !cmp_vld && (idx >= count_r);
  assign count_inc = count_r + PtrW'(1);
  assign count_dec = count_r - PtrW'(1);
  assign shift_dst = cmp_idx - PtrW'(1);

  always_comb begin
    state_next   = state;
    op_next      = op_r;
    id_next      = id_r;
    count_next   = count_r;
    idx_next     = idx;
    cmp_vld_next = cmp_vld;
    cmp_idx_next = cmp_idx;
    done_next    = 1'b0;
    result_next  = result;
    rd_en        = 1'b0;
    rd_addr      = idx[IdxW-1:0];
    wr_en        = 1'b0;
    wr_addr      = count_r[IdxW-1:0];
    wr_data      = id_r;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          op_next = cmd.opcode;
          id_next = cmd.item_id;
          if (cmd.opcode == OP_CLEAR) begin
            count_next  = '0;
            done_next   = 1'b1;
            result_next = '{success: 1'b1, status: ST_OK, entry_count: '0};
          end else begin
            state_next   = S_SCAN;
            idx_next     = '0;
            cmp_vld_next = 1'b0;
          end
        end
      end

      S_SCAN: begin
        if (hit || scan_end) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
          result_next.entry_count = count_r[CNT_W-1:0];
          unique case (op_r)
            OP_ADD: begin
              if (hit) begin
                result_next.success = 1'b0;
                result_next.status  = ST_PRESENT;
              end else if (full) begin
                result_next.success = 1'b0;
                result_next.status  = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                count_next = count_inc;
                result_next.success     = 1'b1;
                result_next.status      = ST_OK;
                result_next.entry_count = count_inc[CNT_W-1:0];
              end
            end
            OP_REMOVE: begin
              if (hit) begin
                state_next   = S_SHIFT;
                done_next    = 1'b0;
                idx_next     = cmp_idx + PtrW'(1);
                cmp_vld_next = 1'b0;
              end else begin
                result_next.success = 1'b0;
                result_next.status  = ST_NOT_FOUND;
              end
            end
            OP_QUERY: begin
              result_next.success = hit;
              result_next.status  = hit ? ST_OK : ST_NOT_FOUND;
            end
            OP_CLEAR: begin
              count_next  = '0;
              result_next = '{success: 1'b1, status: ST_OK, entry_count: '0};
            end
          endcase
        end else if (idx < count_r) begin
          rd_en        = 1'b1;
          idx_next     = idx + PtrW'(1);
          cmp_vld_next = 1'b1;
          cmp_idx_next = idx;
        end else begin
          cmp_vld_next = 1'b0;
        end
      end

      S_SHIFT: begin
        if (cmp_vld) begin
          wr_en   = 1'b1;
          wr_addr = shift_dst[IdxW-1:0];
          wr_data = rd_data;
        end
        if (idx < count_r) begin
          rd_en        = 1'b1;
          idx_next     = idx + PtrW'(1);
          cmp_vld_next = 1'b1;
          cmp_idx_next = idx;
        end else begin
          cmp_vld_next = 1'b0;
          if (!cmp_vld) begin
            count_next  = count_dec;
            state_next  = S_IDLE;
            done_next   = 1'b1;
            result_next = '{success: 1'b1, status: ST_OK,
                            entry_count: count_dec[CNT_W-1:0]};
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count_r <= '0;
      max_r   <= CNT_W'(MAX_ENTRIES_DEF);
      done    <= 1'b0;
      cmp_vld <= 1'b0;
    end else begin
      state   <= state_next;
      count_r <= count_next;
      done    <= done_next;
      cmp_vld <= cmp_vld_next;
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_next;
    id_r    <= id_next;
    idx     <= idx_next;
    cmp_idx <= cmp_idx_next;
    result  <= result_next;
  end

  `BIST_ASSERT_NOW(a_done_idle, clk, rst, done, !busy)
  `BIST_ASSERT_NEXT(a_start_progress, clk, rst, start && !busy, busy || done)
  `BIST_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count_r <= PtrW'(MAX_ENTRIES))
  `BIST_ASSERT_NOW(a_success_ok, clk, rst, done && result.success, result.status == ST_OK)

endmodule

`default_nettype wire
